// File: hw/rtl/cvf_pkg.sv
// ----------------------------------------------------------------------------
// cvf_pkg
// Shared constants, types and codes for the clamped vertex find-or-insert
// table: table sizing, field widths, register codes and the cell chain types.
// ----------------------------------------------------------------------------
package cvf_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int COORD_W  = 16;
  localparam int HEIGHT_W = 32;
  localparam int VIDX_W   = 10;

  // Configuration register reset values
  localparam logic signed [COORD_W-1:0] LOW_BOUND_RESET  = -16'sd3000;
  localparam logic signed [COORD_W-1:0] HIGH_BOUND_RESET = 16'sd3000;

  // Configuration register select codes (paddr bit 2)
  localparam logic REG_LOW_BOUND  = 1'b0;
  localparam logic REG_HIGH_BOUND = 1'b1;

  // Clamped search key, broadcast to every cell
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [HEIGHT_W-1:0]       h;
  } key_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
  } token_t;

  // Append request, broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } wr_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

// File: hw/rtl/clamped_vertex_find_or_insert.sv
// ----------------------------------------------------------------------------
// clamped_vertex_find_or_insert
// Clamped vertex dedup table: finds a stored vertex or appends a new one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready): one word is a vertex pos_x, pos_y,
//   height. Coordinates are clamped to [low_bound, high_bound]; a coordinate
//   at or beyond either bound forces the height to zero.
//   Result channel (out_valid / out_ready): one word per vertex with the
//   index of the matching or appended entry, was_added and table_full.
//   APB port: register 0 low_bound at 0x0, register 1 high_bound at 0x4.
//   Write only while no vertex is in flight.
// Sequencing:
//   The search token walks the chain of TABLE_DEPTH cells, one cell per
//   cycle. A new vertex is accepted only once the previous vertex's result
//   has been handed on to the output register.
// Reset:
//   The table is empty and the bounds return to -3000 / 3000.
// Stall:
//   A result waiting in the output register does not block acceptance of
//   the next vertex; that vertex's result holds until the register frees.
// ----------------------------------------------------------------------------
module clamped_vertex_find_or_insert (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cvf_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [cvf_pkg::COORD_W-1:0]   in_pos_y,
  input  logic signed [cvf_pkg::HEIGHT_W-1:0]  in_height,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cvf_pkg::VIDX_W-1:0]           out_vertex_index,
  output logic                                 out_was_added,
  output logic                                 out_table_full
);
  import cvf_pkg::*;

  logic signed [COORD_W-1:0] low_bound_r;
  logic signed [COORD_W-1:0] high_bound_r;
  logic                      cfg_write;
  key_t                      key;
  logic [CNT_W-1:0]          entry_count;
  wr_t                       wr;
  token_t                    chain [TABLE_DEPTH+1];

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_bound_r  <= LOW_BOUND_RESET;
      high_bound_r <= HIGH_BOUND_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LOW_BOUND:  low_bound_r  <= pwdata[COORD_W-1:0];
        REG_HIGH_BOUND: high_bound_r <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended
  always_comb begin
    unique case (paddr[2])
      REG_LOW_BOUND:  prdata = 32'(low_bound_r);
      REG_HIGH_BOUND: prdata = 32'(high_bound_r);
      default:        prdata = '0;
    endcase
  end

  // Sequencer
  cvf_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .low_bound        (low_bound_r),
    .high_bound       (high_bound_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_height        (in_height),
    .key              (key),
    .entry_count      (entry_count),
    .wr               (wr),
    .tok_head         (chain[0]),
    .tok_tail         (chain[TABLE_DEPTH]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_was_added    (out_was_added),
    .out_table_full   (out_table_full)
  );

  // Chain of table cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cvf_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (IDX_W'(g)),
      .key         (key),
      .entry_count (entry_count),
      .wr          (wr),
      .tok_in      (chain[g]),
      .tok_out     (chain[g+1])
    );
  end

endmodule

// File: hw/rtl/cvf_cell.sv
// ----------------------------------------------------------------------------
// cvf_cell
// One table entry of the chain. Holds a stored vertex, compares it with the
// broadcast key when the search token passes, and hands the token on.
// ----------------------------------------------------------------------------
module cvf_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cvf_pkg::IDX_W-1:0]    cell_idx,
  input  cvf_pkg::key_t                key,
  input  logic [cvf_pkg::CNT_W-1:0]    entry_count,
  input  cvf_pkg::wr_t                 wr,
  input  cvf_pkg::token_t              tok_in,
  output cvf_pkg::token_t              tok_out
);
  import cvf_pkg::*;

  key_t   entry_r;
  token_t tok_r;
  token_t tok_nxt;
  logic   occupied;
  logic   match;

  // Entry is live only below the fill count
  assign occupied = ({1'b0, cell_idx} < entry_count);
  assign match    = tok_in.valid && occupied && (entry_r == key);

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found | match;
    if (match) begin
      tok_nxt.idx = cell_idx;
    end
  end

  // Stored vertex, loaded on append
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == cell_idx)) begin
      entry_r <= key;
    end
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// File: hw/rtl/cvf_ctrl.sv
// ----------------------------------------------------------------------------
// cvf_ctrl
// Sequencer: clamps the incoming vertex into the key register, launches the
// search token, resolves match / append / full when the token leaves the
// chain, keeps the fill count and drives the result register.
// ----------------------------------------------------------------------------
module cvf_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [cvf_pkg::COORD_W-1:0]   low_bound,
  input  logic signed [cvf_pkg::COORD_W-1:0]   high_bound,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cvf_pkg::COORD_W-1:0]   in_pos_x,
  input  logic signed [cvf_pkg::COORD_W-1:0]   in_pos_y,
  input  logic signed [cvf_pkg::HEIGHT_W-1:0]  in_height,
  output cvf_pkg::key_t                        key,
  output logic [cvf_pkg::CNT_W-1:0]            entry_count,
  output cvf_pkg::wr_t                         wr,
  output cvf_pkg::token_t                      tok_head,
  input  cvf_pkg::token_t                      tok_tail,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cvf_pkg::VIDX_W-1:0]           out_vertex_index,
  output logic                                 out_was_added,
  output logic                                 out_table_full
);
  import cvf_pkg::*;

  state_t             state_r, state_nxt;
  key_t               key_r, key_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               head_valid_r, head_valid_nxt;
  logic [VIDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic               res_added_r, res_added_nxt;
  logic               res_full_r, res_full_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic               out_added_r, out_added_nxt;
  logic               out_full_r, out_full_nxt;
  logic               accept;
  logic               hit;
  logic               is_full;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;

  // Clamp: low bound first, then high bound on its result
  always_comb begin
    hit = 1'b0;
    cx  = in_pos_x;
    if (cx <= low_bound) begin
      cx  = low_bound;
      hit = 1'b1;
    end
    if (cx >= high_bound) begin
      cx  = high_bound;
      hit = 1'b1;
    end
    cy = in_pos_y;
    if (cy <= low_bound) begin
      cy  = low_bound;
      hit = 1'b1;
    end
    if (cy >= high_bound) begin
      cy  = high_bound;
      hit = 1'b1;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(TABLE_DEPTH));

  // Next state and outputs
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    head_valid_nxt = 1'b0;
    res_idx_nxt    = res_idx_r;
    res_added_nxt  = res_added_r;
    res_full_nxt   = res_full_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_idx_nxt    = out_idx_r;
    out_added_nxt  = out_added_r;
    out_full_nxt   = out_full_r;
    wr.en          = 1'b0;
    wr.addr        = count_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt.x      = cx;
          key_nxt.y      = cy;
          key_nxt.h      = hit ? '0 : HEIGHT_W'(in_height);
          head_valid_nxt = 1'b1;
          state_nxt      = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tok_tail.valid) begin
          if (tok_tail.found) begin
            res_idx_nxt   = VIDX_W'(tok_tail.idx);
            res_added_nxt = 1'b0;
            res_full_nxt  = 1'b0;
          end else if (is_full) begin
            res_idx_nxt   = '0;
            res_added_nxt = 1'b0;
            res_full_nxt  = 1'b1;
          end else begin
            wr.en         = 1'b1;
            count_nxt     = count_r + 1'b1;
            res_idx_nxt   = VIDX_W'(count_r);
            res_added_nxt = 1'b1;
            res_full_nxt  = 1'b0;
          end
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_added_nxt = res_added_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      head_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_valid_r <= head_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    res_idx_r   <= res_idx_nxt;
    res_added_r <= res_added_nxt;
    res_full_r  <= res_full_nxt;
    out_idx_r   <= out_idx_nxt;
    out_added_r <= out_added_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign key            = key_r;
  assign entry_count    = count_r;
  assign tok_head.valid = head_valid_r;
  assign tok_head.found = 1'b0;
  assign tok_head.idx   = '0;

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_was_added    = out_added_r;
  assign out_table_full   = out_full_r;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamped vertex find-or-insert table. A short
// table of directed vertices and bound settings comes first, then random
// phases under several bound settings that fill the table to its limit and
// keep going past it. Each result word is checked against its directed row's
// expected word where given, else against a local model of clamp, search, append.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cvf_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_AT     = 400;
  localparam int HOLDOFF_CYCLES = 3500;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 290;
  localparam int IDLE_PCT       = 22;
  localparam int RECENT_DEPTH   = 256;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [HEIGHT_W-1:0]       h;
  } vertex_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              was_added;
    logic              table_full;
  } lookup_t;

  typedef enum logic {ROW_VERTEX, ROW_BOUNDS} row_kind_t;

  // Bounds rows carry low in x and high in y
  typedef struct packed {
    row_kind_t                 kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [HEIGHT_W-1:0]       h;
    logic                      has_want;
    lookup_t                   want;
  } stim_row_t;

  localparam int NUM_ROWS = 25;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // fresh table, reset bounds -3000 / 3000
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h0000_0000, 1'b1, '{10'd0, 1'b1, 1'b0}},
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h0000_0000, 1'b1, '{10'd0, 1'b0, 1'b0}},
    '{ROW_VERTEX, 16'sh8000,   16'sd0,      32'h1234_5678, 1'b1, '{10'd1, 1'b1, 1'b0}},
    '{ROW_VERTEX, -16'sd5000,  16'sd0,      32'h7FFF_FFFF, 1'b1, '{10'd1, 1'b0, 1'b0}},
    '{ROW_VERTEX, 16'sh7FFF,   16'sh7FFF,   32'h7FFF_FFFF, 1'b1, '{10'd2, 1'b1, 1'b0}},
    '{ROW_VERTEX, 16'sd0,      16'sh8000,   32'h8000_0000, 1'b1, '{10'd3, 1'b1, 1'b0}},
    // exactly on the bounds and just inside
    '{ROW_VERTEX, -16'sd3000,  16'sd5,      32'h0001_0000, 1'b0, '0},
    '{ROW_VERTEX, -16'sd2999,  16'sd5,      32'h0001_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sd2999,   -16'sd2999,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_VERTEX, 16'sd3000,   16'sd0,      32'hFFFF_FFFF, 1'b0, '0},
    // height patterns, coordinates inside the bounds
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h8000_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h0000_0001, 1'b0, '0},
    '{ROW_VERTEX, -16'sd1,     -16'sd1,     32'hFFFF_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h8000_0000, 1'b0, '0},
    // crossed bounds: low clamp first, then high
    '{ROW_BOUNDS, 16'sd100,    -16'sd100,   32'h0000_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sd0,      16'sd0,      32'h0001_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sh7FFF,   16'sh8000,   32'h5555_AAAA, 1'b0, '0},
    // widest bounds
    '{ROW_BOUNDS, 16'sh8000,   16'sh7FFF,   32'h0000_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sh8000,   16'sh7FFF,   32'hAAAA_5555, 1'b0, '0},
    '{ROW_VERTEX, -16'sd32767, 16'sd32766,  32'hAAAA_5555, 1'b0, '0},
    // both bounds equal: everything collapses to one point
    '{ROW_BOUNDS, 16'sd0,      16'sd0,      32'h0000_0000, 1'b0, '0},
    '{ROW_VERTEX, 16'sd5,      -16'sd5,     32'h0000_0007, 1'b0, '0},
    '{ROW_BOUNDS, -16'sd3000,  16'sd3000,   32'h0000_0000, 1'b0, '0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [COORD_W-1:0]  in_pos_x;
  logic signed [COORD_W-1:0]  in_pos_y;
  logic signed [HEIGHT_W-1:0] in_height;
  logic                       out_valid;
  logic                       out_ready;
  logic [VIDX_W-1:0]          out_vertex_index;
  logic                       out_was_added;
  logic                       out_table_full;

  // Local copy of the table and bounds
  logic signed [COORD_W-1:0] shadow_low;
  logic signed [COORD_W-1:0] shadow_high;
  logic signed [COORD_W-1:0] shadow_x [TABLE_DEPTH];
  logic signed [COORD_W-1:0] shadow_y [TABLE_DEPTH];
  logic [HEIGHT_W-1:0]       shadow_h [TABLE_DEPTH];
  int                        shadow_count;

  lookup_t pending_lookups [$];
  vertex_t recent_vertices [$];
  int      errors = 0;
  int      results_seen = 0;

  clamped_vertex_find_or_insert i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_height        (in_height),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_was_added    (out_was_added),
    .out_table_full   (out_table_full)
  );

  always #HALF_PERIOD clk = ~clk;

  // Clamp, search, append; updates the local table
  function automatic lookup_t lookup_vertex(vertex_t v);
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [HEIGHT_W-1:0]       ch;
    logic                      hit;
    logic                      found;
    lookup_t                   r;
    int                        i;
    cx = v.x;
    cy = v.y;
    ch = v.h;
    hit = 1'b0;
    found = 1'b0;
    r = '0;
    if (cx <= shadow_low) begin
      cx = shadow_low;
      hit = 1'b1;
    end
    if (cx >= shadow_high) begin
      cx = shadow_high;
      hit = 1'b1;
    end
    if (cy <= shadow_low) begin
      cy = shadow_low;
      hit = 1'b1;
    end
    if (cy >= shadow_high) begin
      cy = shadow_high;
      hit = 1'b1;
    end
    if (hit) ch = '0;
    for (i = 0; i < shadow_count && !found; i++) begin
      if (shadow_x[i] == cx && shadow_y[i] == cy && shadow_h[i] == ch) begin
        found = 1'b1;
        r.vertex_index = VIDX_W'(i);
      end
    end
    if (!found) begin
      if (shadow_count >= TABLE_DEPTH) begin
        r.table_full = 1'b1;
      end else begin
        shadow_x[shadow_count] = cx;
        shadow_y[shadow_count] = cy;
        shadow_h[shadow_count] = ch;
        r.vertex_index = VIDX_W'(shadow_count);
        r.was_added = 1'b1;
        shadow_count++;
      end
    end
    return r;
  endfunction

  // Coordinate strictly between the bounds, random when there is no room
  function automatic logic signed [COORD_W-1:0] pick_inner();
    int lo;
    int hi;
    lo = int'(shadow_low) + 1;
    hi = int'(shadow_high) - 1;
    if (lo <= hi) return COORD_W'(lo + int'($urandom_range(hi - lo, 0)));
    return COORD_W'($urandom);
  endfunction

  // Coordinate that likely trips a clamp
  function automatic logic signed [COORD_W-1:0] pick_edge();
    case ($urandom_range(4, 0))
      0: return shadow_low;
      1: return shadow_high;
      2: return 16'sh8000;
      3: return 16'sh7FFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Mostly fresh vertices until the table fills, then more repeats, edges and random words
  function automatic vertex_t make_vertex();
    vertex_t v;
    int      fresh_pct;
    fresh_pct = (shadow_count < TABLE_DEPTH) ? 90 : 40;
    v.x = COORD_W'($urandom);
    v.y = COORD_W'($urandom);
    v.h = $urandom;
    if (int'($urandom_range(99, 0)) < fresh_pct) begin
      v.x = pick_inner();
      v.y = pick_inner();
      recent_vertices.push_back(v);
      if (recent_vertices.size() > RECENT_DEPTH) void'(recent_vertices.pop_front());
    end else begin
      case ($urandom_range(2, 0))
        0: begin
          if (recent_vertices.size() != 0)
            v = recent_vertices[$urandom_range(recent_vertices.size() - 1, 0)];
        end
        1: begin
          if ($urandom_range(1, 0) != 0) begin
            v.x = pick_edge();
            v.y = pick_inner();
          end else begin
            v.x = pick_inner();
            v.y = pick_edge();
          end
        end
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic apb_transfer(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_readback(input logic code, input logic signed [COORD_W-1:0] value);
    logic [31:0] rd;
    apb_transfer(1'b0, {code, 2'b00}, '0, rd);
    if (rd[COORD_W-1:0] !== value) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("register %0d read back %h, wrote %h", code, rd[COORD_W-1:0], value);
    end
  endtask

  // Drain, then write both bounds and read them back
  task automatic set_bounds(input int lo, input int hi);
    logic [31:0]               rd;
    logic signed [COORD_W-1:0] lo16;
    logic signed [COORD_W-1:0] hi16;
    lo16 = COORD_W'(lo);
    hi16 = COORD_W'(hi);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    apb_transfer(1'b1, {REG_LOW_BOUND, 2'b00}, 32'(lo16), rd);
    apb_transfer(1'b1, {REG_HIGH_BOUND, 2'b00}, 32'(hi16), rd);
    check_readback(REG_LOW_BOUND, lo16);
    check_readback(REG_HIGH_BOUND, hi16);
    shadow_low  = lo16;
    shadow_high = hi16;
  endtask

  // Offer one vertex word; predict when it is taken
  task automatic send_vertex(input vertex_t v, input logic has_want, input lookup_t want,
                             input logic no_gaps);
    lookup_t predicted;
    if (!no_gaps) begin
      while (int'($urandom_range(99, 0)) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_pos_x  <= v.x;
    in_pos_y  <= v.y;
    in_height <= v.h;
    do @(posedge clk); while (!in_ready);
    predicted = lookup_vertex(v);
    pending_lookups.push_back(has_want ? want : predicted);
  endtask

  // Stimulus
  initial begin : stimulus
    vertex_t v;
    rst_n     <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    in_pos_x  <= '0;
    in_pos_y  <= '0;
    in_height <= '0;
    shadow_low   = LOW_BOUND_RESET;
    shadow_high  = HIGH_BOUND_RESET;
    shadow_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_BOUNDS) begin
        set_bounds(int'(DIRECTED[r].x), int'(DIRECTED[r].y));
      end else begin
        v = '{DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].h};
        send_vertex(v, DIRECTED[r].has_want, DIRECTED[r].want, 1'b0);
      end
    end

    // Random phases; crossed bounds last, when the table is already full
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: set_bounds(-3000, 3000);
        1: set_bounds(-32768, 32767);
        2: set_bounds(-int'($urandom_range(16000, 1)), int'($urandom_range(16000, 1)));
        3: set_bounds(-200, 200);
        4: set_bounds(-1000, 4000);
        default: set_bounds(500, -500);
      endcase
      for (int item = 0; item < PHASE_ITEMS; item++)
        send_vertex(make_vertex(), 1'b0, '0, phase == 1 && item >= 50 && item < 250);
    end

    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (errors == 0) begin
      $display("PASS clamped_vertex_find_or_insert");
    end else begin
      $display("FAIL clamped_vertex_find_or_insert");
    end
    $finish;
  end

  // Result side: check each word, random stalls, an always-ready window, one long hold-off
  initial begin : result_sink
    lookup_t got;
    lookup_t want;
    int      hold_left;
    logic    held;
    hold_left = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_vertex_index, out_was_added, out_table_full};
        results_seen++;
        if (pending_lookups.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result word with nothing pending: index %0d added %0b full %0b",
                     got.vertex_index, got.was_added, got.table_full);
        end else begin
          want = pending_lookups.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("result %0d: index %0d/%0d added %0b/%0b full %0b/%0b (exp/got)",
                       results_seen, want.vertex_index, got.vertex_index,
                       want.was_added, got.was_added, want.table_full, got.table_full);
          end
        end
      end
      if (results_seen == HOLDOFF_AT && !held) begin
        held = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 900 && results_seen < 1100) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= (int'($urandom_range(99, 0)) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any word moving
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL clamped_vertex_find_or_insert");
    $finish;
  end

endmodule
